@@ rtl/clm_pkg.sv @@
package clm_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_NOM_LO  = 3'd0,
    REG_NOM_HI  = 3'd1,
    REG_MEAS_LO = 3'd2,
    REG_MEAS_HI = 3'd3,
    REG_MAG_LO  = 3'd4,
    REG_MAG_HI  = 3'd5,
    REG_MAG_OFF = 3'd6,
    REG_UNUSED  = 3'd7
  } reg_idx_t;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOM_ZERO  = 2'd1;
  localparam logic [1:0] ST_MEAS_ZERO = 2'd2;

  // override applied at the output instead of the quotient
  typedef enum logic [1:0] {
    FORCE_NONE    = 2'd0,
    FORCE_ERR     = 2'd1,
    FORCE_SAT_POS = 2'd2,
    FORCE_SAT_NEG = 2'd3
  } force_t;

  localparam int CNT_PER_MA   = 183;
  localparam int SNAP_MILLI   = 10;
  localparam logic signed [31:0] ERR_MAG = -32'sd999000;

  localparam int QW           = 32;  // quotient bits
  localparam int DW           = 25;  // divisor bits (2 * 183 * 65535 < 2**25)
  localparam int NW           = 53;  // dividend bits
  localparam int BITS_PER_STG = 2;
  localparam int DIV_STAGES   = QW / BITS_PER_STG;
  localparam int FRONT_STAGES = 4;

  // side information traveling with each beat
  typedef struct packed {
    logic [12:0] raw_count;
    logic [1:0]  status;
    force_t      force_code;
    logic        neg;
    logic        snap;
    logic        ovf;
  } side_t;

  // divider working set
  typedef struct packed {
    logic [DW-1:0] rem;
    logic [QW-1:0] num;
    logic [DW-1:0] dvs;
    logic [QW-1:0] quo;
  } div_t;

endpackage

@@ rtl/clm_front.sv @@
module clm_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_vld,
  input  logic [15:0]             in_word,
  input  logic [7:0]              nom_lo,
  input  logic [7:0]              nom_hi,
  input  logic [15:0]             meas_lo,
  input  logic [15:0]             meas_hi,
  input  logic signed [23:0]      mag_lo,
  input  logic signed [23:0]      mag_hi,
  input  logic signed [23:0]      mag_off,
  output logic                    out_vld,
  output clm_pkg::side_t          out_side,
  output clm_pkg::div_t           out_div
);

  // ---- stage A: operands from the word and the calibration registers
  logic [12:0]        raw;
  logic signed [16:0] de;
  logic signed [24:0] den;
  logic [23:0]        meas_prod;
  logic signed [24:0] x_nxt, mspan_full, mspan_nxt, base_nxt;
  logic [23:0]        ud_nxt;
  logic               sx_p, sx_n, sm_p, sm_n;
  clm_pkg::side_t     sa_nxt;

  logic               a_vld_r;
  clm_pkg::side_t     a_side_r;
  logic signed [24:0] a_x_r, a_mspan_r, a_base_r;
  logic [23:0]        a_ud_r;
  logic               a_dneg_r;

  always_comb begin
    raw        = in_word[15:3];
    de         = $signed({1'b0, meas_hi}) - $signed({1'b0, meas_lo});
    den        = 25'(de * 25'sd183);
    meas_prod  = 24'(meas_lo) * 24'd183;
    x_nxt      = $signed({2'b00, raw, 10'b0}) - $signed({1'b0, meas_prod});
    mspan_full = 25'(mag_hi) - 25'(mag_lo);
    base_nxt   = 25'(mag_lo) + 25'(mag_off);
    sx_p       = x_nxt > 0;
    sx_n       = x_nxt < 0;
    sm_p       = mspan_full > 0;
    sm_n       = mspan_full < 0;
    sa_nxt            = '0;
    sa_nxt.raw_count  = raw;
    sa_nxt.force_code = clm_pkg::FORCE_NONE;
    sa_nxt.status     = clm_pkg::ST_OK;
    mspan_nxt         = mspan_full;
    ud_nxt            = de < 0 ? 24'(-den) : 24'(den);
    if (nom_lo == nom_hi) begin
      sa_nxt.status     = clm_pkg::ST_NOM_ZERO;
      sa_nxt.force_code = clm_pkg::FORCE_ERR;
    end else if (de == 0) begin
      sa_nxt.status = clm_pkg::ST_MEAS_ZERO;
      if ((sx_p && sm_p) || (sx_n && sm_n)) sa_nxt.force_code = clm_pkg::FORCE_SAT_POS;
      else if ((sx_p && sm_n) || (sx_n && sm_p)) sa_nxt.force_code = clm_pkg::FORCE_SAT_NEG;
    end
    // zero measured span: fall back to base / 1
    if (de == 0) begin
      mspan_nxt = '0;
      ud_nxt    = 24'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= in_vld;
    a_side_r  <= sa_nxt;
    a_x_r     <= x_nxt;
    a_mspan_r <= mspan_nxt;
    a_base_r  <= base_nxt;
    a_ud_r    <= ud_nxt;
    a_dneg_r  <= de < 0;
  end

  // ---- stage B: the two products
  logic               b_vld_r;
  clm_pkg::side_t     b_side_r;
  logic signed [49:0] b_num_r, b_bd_r;
  logic [23:0]        b_ud_r;
  logic               b_dneg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else        b_vld_r <= a_vld_r;
    b_side_r <= a_side_r;
    b_num_r  <= 50'(a_mspan_r) * 50'(a_x_r);
    b_bd_r   <= 50'(a_base_r) * $signed({26'b0, a_ud_r});
    b_ud_r   <= a_ud_r;
    b_dneg_r <= a_dneg_r;
  end

  // ---- stage C: numerator total over positive denominator
  logic               c_vld_r;
  clm_pkg::side_t     c_side_r;
  logic signed [51:0] c_total_r;
  logic [23:0]        c_ud_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else        c_vld_r <= b_vld_r;
    c_side_r  <= b_side_r;
    c_total_r <= b_dneg_r ? 52'(b_bd_r) - 52'(b_num_r) : 52'(b_bd_r) + 52'(b_num_r);
    c_ud_r    <= b_ud_r;
  end

  // ---- stage D: magnitude, snap, rounding dividend, overflow check
  logic [50:0]                 mag;
  logic [clm_pkg::NW-1:0]      nval;
  logic [clm_pkg::DW-1:0]      dval;
  logic [27:0]                 snap_lim;
  logic                        ovf;
  clm_pkg::side_t              sd_nxt;
  clm_pkg::div_t               dd_nxt;

  always_comb begin
    mag      = c_total_r < 0 ? 51'(-c_total_r) : 51'(c_total_r);
    nval     = {mag, 1'b0} + 53'(c_ud_r);
    dval     = {c_ud_r, 1'b0};
    snap_lim = 28'(c_ud_r) * 28'(clm_pkg::SNAP_MILLI);
    ovf      = 25'(nval[clm_pkg::NW-1:clm_pkg::QW]) >= dval;
    sd_nxt      = c_side_r;
    sd_nxt.neg  = c_total_r < 0;
    sd_nxt.snap = 51'(snap_lim) > mag;
    sd_nxt.ovf  = ovf;
    dd_nxt.rem  = ovf ? '0 : 25'(nval[clm_pkg::NW-1:clm_pkg::QW]);
    dd_nxt.num  = nval[clm_pkg::QW-1:0];
    dd_nxt.dvs  = dval;
    dd_nxt.quo  = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld <= 1'b0;
    else        out_vld <= c_vld_r;
    out_side <= sd_nxt;
    out_div  <= dd_nxt;
  end

endmodule

@@ rtl/clm_div_stage.sv @@
module clm_div_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_vld,
  input  clm_pkg::side_t  in_side,
  input  clm_pkg::div_t   in_div,
  output logic            out_vld,
  output clm_pkg::side_t  out_side,
  output clm_pkg::div_t   out_div
);

  // restoring division, a few quotient bits per stage
  clm_pkg::div_t          d_nxt;
  logic [clm_pkg::DW:0]   trial;

  always_comb begin
    d_nxt = in_div;
    trial = '0;
    for (int k = 0; k < clm_pkg::BITS_PER_STG; k++) begin
      trial     = {d_nxt.rem, d_nxt.num[clm_pkg::QW-1]};
      d_nxt.num = {d_nxt.num[clm_pkg::QW-2:0], 1'b0};
      if (trial >= {1'b0, d_nxt.dvs}) begin
        trial     = trial - {1'b0, d_nxt.dvs};
        d_nxt.quo = {d_nxt.quo[clm_pkg::QW-2:0], 1'b1};
      end else begin
        d_nxt.quo = {d_nxt.quo[clm_pkg::QW-2:0], 1'b0};
      end
      d_nxt.rem = trial[clm_pkg::DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_vld <= 1'b0;
    else        out_vld <= in_vld;
    out_side <= in_side;
    out_div  <= d_nxt;
  end

endmodule

@@ rtl/current_loop_to_magnitude.sv @@
// Current-loop to magnitude converter.
// Input: pulse start with in_reading_word; a beat is taken whenever start is
// high and busy is low. busy stays low: a new beat may enter every cycle.
// Output: out_valid is high for one cycle with out_raw_count, out_magnitude
// (milli-units, saturated) and out_status. The receiver cannot hold results.
// Throughput is one beat per cycle. Four front stages form the operands, the
// products and the rounded dividend; a 16-stage restoring divider (2 quotient
// bits per stage) forms the quotient; one stage applies sign, snap and
// saturation.
// Configuration: cfg_we writes cfg_wdata to register cfg_index at once;
// write only while no beat is in flight. Index 7 is ignored.
// Reset (synchronous, rst_n low) restores the default calibration and
// drops every beat in flight.
module current_loop_to_magnitude (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        in_reading_word,
  output logic               out_valid,
  output logic [12:0]        out_raw_count,
  output logic signed [31:0] out_magnitude,
  output logic [1:0]         out_status,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);

  // calibration registers
  logic [7:0]         nom_lo_r, nom_hi_r;
  logic [15:0]        meas_lo_r, meas_hi_r;
  logic signed [23:0] mag_lo_r, mag_hi_r, mag_off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nom_lo_r  <= 8'd0;
      nom_hi_r  <= 8'd20;
      meas_lo_r <= 16'd0;
      meas_hi_r <= 16'd20480;
      mag_lo_r  <= 24'sd0;
      mag_hi_r  <= 24'sd6000;
      mag_off_r <= 24'sd0;
    end else if (cfg_we) begin
      unique case (clm_pkg::reg_idx_t'(cfg_index))
        clm_pkg::REG_NOM_LO:  nom_lo_r  <= cfg_wdata[7:0];
        clm_pkg::REG_NOM_HI:  nom_hi_r  <= cfg_wdata[7:0];
        clm_pkg::REG_MEAS_LO: meas_lo_r <= cfg_wdata[15:0];
        clm_pkg::REG_MEAS_HI: meas_hi_r <= cfg_wdata[15:0];
        clm_pkg::REG_MAG_LO:  mag_lo_r  <= cfg_wdata;
        clm_pkg::REG_MAG_HI:  mag_hi_r  <= cfg_wdata;
        clm_pkg::REG_MAG_OFF: mag_off_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // front stages
  logic           vld   [clm_pkg::DIV_STAGES+1];
  clm_pkg::side_t side  [clm_pkg::DIV_STAGES+1];
  clm_pkg::div_t  dwork [clm_pkg::DIV_STAGES+1];

  clm_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .in_word  (in_reading_word),
    .nom_lo   (nom_lo_r),
    .nom_hi   (nom_hi_r),
    .meas_lo  (meas_lo_r),
    .meas_hi  (meas_hi_r),
    .mag_lo   (mag_lo_r),
    .mag_hi   (mag_hi_r),
    .mag_off  (mag_off_r),
    .out_vld  (vld[0]),
    .out_side (side[0]),
    .out_div  (dwork[0])
  );

  // divider chain
  for (genvar g = 0; g < clm_pkg::DIV_STAGES; g++) begin : g_div
    clm_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_vld   (vld[g]),
      .in_side  (side[g]),
      .in_div   (dwork[g]),
      .out_vld  (vld[g+1]),
      .out_side (side[g+1]),
      .out_div  (dwork[g+1])
    );
  end

  // output stage: overrides, snap, sign and saturation
  clm_pkg::side_t     fs;
  logic [31:0]        q;
  logic signed [31:0] mag_nxt;

  always_comb begin
    fs = side[clm_pkg::DIV_STAGES];
    q  = dwork[clm_pkg::DIV_STAGES].quo;
    unique case (fs.force_code)
      clm_pkg::FORCE_ERR:     mag_nxt = clm_pkg::ERR_MAG;
      clm_pkg::FORCE_SAT_POS: mag_nxt = 32'sh7FFF_FFFF;
      clm_pkg::FORCE_SAT_NEG: mag_nxt = 32'sh8000_0000;
      default: begin
        if (fs.snap)                          mag_nxt = '0;
        else if (!fs.neg && (fs.ovf || q[31])) mag_nxt = 32'sh7FFF_FFFF;
        else if (fs.neg && (fs.ovf || q > 32'h8000_0000)) mag_nxt = 32'sh8000_0000;
        else if (fs.neg)                      mag_nxt = $signed(-q);
        else                                  mag_nxt = $signed(q);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= vld[clm_pkg::DIV_STAGES];
    out_raw_count <= fs.raw_count;
    out_status    <= fs.status;
    out_magnitude <= mag_nxt;
  end

endmodule

@@ rtl/clm_checker.sv @@
module clm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic [15:0]        in_reading_word,
  input logic               out_valid,
  input logic [12:0]        out_raw_count,
  input logic signed [31:0] out_magnitude,
  input logic [1:0]         out_status
);

  localparam int LAT = clm_pkg::FRONT_STAGES + clm_pkg::DIV_STAGES + 1;

  // cycles since reset, saturating at the pipeline latency
  logic [5:0] age_r;
  logic       warm;

  always_ff @(posedge clk) begin
    if (!rst_n)                 age_r <= '0;
    else if (age_r != 6'(LAT)) age_r <= age_r + 6'd1;
  end
  assign warm = age_r == 6'(LAT);

  // each accepted beat yields exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    warm |-> out_valid == $past(start && !busy, LAT))
    else $error("result strobe does not match accepted beat");

  // raw count follows its beat through the pipeline
  a_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (warm && out_valid) |-> out_raw_count == $past(in_reading_word[15:3], LAT))
    else $error("raw count does not match accepted beat");

  // nominal span error always carries the error magnitude
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == clm_pkg::ST_NOM_ZERO) |-> out_magnitude == clm_pkg::ERR_MAG)
    else $error("error status without error magnitude");

  // status never takes the unused code
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == clm_pkg::ST_OK || out_status == clm_pkg::ST_NOM_ZERO ||
                   out_status == clm_pkg::ST_MEAS_ZERO))
    else $error("unused status code");

endmodule

bind current_loop_to_magnitude clm_checker u_clm_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .start           (start),
  .busy            (busy),
  .in_reading_word (in_reading_word),
  .out_valid       (out_valid),
  .out_raw_count   (out_raw_count),
  .out_magnitude   (out_magnitude),
  .out_status      (out_status)
);

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;

  // one result beat
  typedef struct {
    logic [12:0]        raw_count;
    logic signed [31:0] magnitude;
    logic [1:0]         status;
  } scaled_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [15:0]        in_reading_word;
  logic               out_valid;
  logic [12:0]        out_raw_count;
  logic signed [31:0] out_magnitude;
  logic [1:0]         out_status;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [23:0]        cfg_wdata;

  // calibration mirror
  logic [7:0]         nom_lo, nom_hi;
  logic [15:0]        meas_lo, meas_hi;
  logic signed [23:0] mag_lo, mag_hi, mag_off;

  scaled_t pending_q[$];
  int      errors;
  int      beats_sent;
  int      beats_seen;
  int      cfg_writes;
  int      idle_pct;
  longint  cycles;

  localparam longint CYCLE_LIMIT = 200000;
  localparam int     DRAIN_CYCLES = 30;

  current_loop_to_magnitude dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // round to milli-units, snap small values, saturate; den > 0
  function automatic longint round_snap(longint total, longint den);
    longint mag, q;
    mag = (total < 0) ? -total : total;
    if (mag < clm_pkg::SNAP_MILLI * den) return 0;
    q = (2 * mag + den) / (2 * den);
    if (total < 0) q = -q;
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q;
  endfunction

  function automatic scaled_t scale_reading(logic [15:0] word);
    scaled_t r;
    longint raw, dn, de, x, mlo, mspan, base, den, num, m;
    int sx, sm;
    raw = longint'(word >> 3);
    dn = longint'(nom_hi) - longint'(nom_lo);
    r.raw_count = raw[12:0];
    r.status = clm_pkg::ST_OK;
    if (dn == 0) begin
      m = clm_pkg::ERR_MAG;
      r.status = clm_pkg::ST_NOM_ZERO;
    end else begin
      de = longint'(meas_hi) - longint'(meas_lo);
      x = 1024 * raw - clm_pkg::CNT_PER_MA * longint'(meas_lo);
      mlo = longint'(mag_lo);
      mspan = longint'(mag_hi) - mlo;
      base = mlo + longint'(mag_off);
      if (de == 0) begin
        r.status = clm_pkg::ST_MEAS_ZERO;
        sx = int'(x > 0) - int'(x < 0);
        sm = int'(mspan > 0) - int'(mspan < 0);
        if (sx * sm > 0) m = 64'sd2147483647;
        else if (sx * sm < 0) m = -64'sd2147483648;
        else m = round_snap(base, 1);
      end else begin
        den = clm_pkg::CNT_PER_MA * de;
        num = mspan * x;
        if (den < 0) begin
          den = -den;
          num = -num;
        end
        m = round_snap(base * den + num, den);
      end
    end
    r.magnitude = m[31:0];
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    scaled_t exp_r;
    if (rst_n && out_valid) begin
      beats_seen++;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result raw %0d mag %0d status %0d",
                 $time, out_raw_count, out_magnitude, out_status);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_raw_count !== exp_r.raw_count) begin
          $display("%0t: raw_count expected %0d actual %0d",
                   $time, exp_r.raw_count, out_raw_count);
          errors++;
        end
        if (out_magnitude !== exp_r.magnitude) begin
          $display("%0t: magnitude expected %0d actual %0d",
                   $time, exp_r.magnitude, out_magnitude);
          errors++;
        end
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d",
                   $time, exp_r.status, out_status);
          errors++;
        end
      end
    end
  end

  // send one beat, then maybe idle
  task automatic send_reading(logic [15:0] word);
    start <= 1'b1;
    in_reading_word <= word;
    do @(posedge clk); while (busy);
    pending_q.push_back(scale_reading(word));
    beats_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (pending_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write, only with the pipe empty
  task automatic write_reg(clm_pkg::reg_idx_t idx, logic [23:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      clm_pkg::REG_NOM_LO:  nom_lo = val[7:0];
      clm_pkg::REG_NOM_HI:  nom_hi = val[7:0];
      clm_pkg::REG_MEAS_LO: meas_lo = val[15:0];
      clm_pkg::REG_MEAS_HI: meas_hi = val[15:0];
      clm_pkg::REG_MAG_LO:  mag_lo = val;
      clm_pkg::REG_MAG_HI:  mag_hi = val;
      clm_pkg::REG_MAG_OFF: mag_off = val;
      default: ;
    endcase
  endtask

  task automatic set_calibration(logic [7:0] nl, logic [7:0] nh, logic [15:0] ml,
                                 logic [15:0] mh, logic [23:0] al, logic [23:0] ah,
                                 logic [23:0] ao);
    write_reg(clm_pkg::REG_NOM_LO, {16'd0, nl});
    write_reg(clm_pkg::REG_NOM_HI, {16'd0, nh});
    write_reg(clm_pkg::REG_MEAS_LO, {8'd0, ml});
    write_reg(clm_pkg::REG_MEAS_HI, {8'd0, mh});
    write_reg(clm_pkg::REG_MAG_LO, al);
    write_reg(clm_pkg::REG_MAG_HI, ah);
    write_reg(clm_pkg::REG_MAG_OFF, ao);
  endtask

  // reset calibration, word extremes
  task automatic test_default_cal();
    send_reading(16'h0000);
    send_reading(16'h0007);
    send_reading(16'h0008);
    send_reading(16'hFFFF);
    send_reading(16'hAAAA);
    send_reading(16'h5555);
    send_reading(16'h0010);
  endtask

  // nominal span zero wins over measured span zero
  task automatic test_nominal_zero();
    set_calibration(8'd4, 8'd4, 16'd100, 16'd100, 24'd0, 24'd1000, 24'd0);
    send_reading(16'h1234);
    send_reading(16'hFFFF);
  endtask

  // measured span zero: positive, negative and zero sign
  task automatic test_measured_zero();
    set_calibration(8'd4, 8'd20, 16'd0, 16'd0, 24'd3, 24'd5000, 24'd2);
    send_reading(16'h0000);
    send_reading(16'h0008);
    write_reg(clm_pkg::REG_MAG_HI, -24'sd5000);
    send_reading(16'h0008);
    write_reg(clm_pkg::REG_MAG_OFF, 24'd20);
    send_reading(16'h0007);
  endtask

  // reversed spans, near-zero snap, saturation, ignored index
  task automatic test_edges();
    set_calibration(8'd20, 8'd4, 16'd20480, 16'd4096, -24'sd8, 24'd8, 24'd0);
    send_reading(16'h0000);
    send_reading(16'h1000);
    send_reading(16'hFFFF);
    set_calibration(8'd0, 8'd255, 16'd0, 16'd1, 24'h800000, 24'h7FFFFF,
                    24'h7FFFFF);
    send_reading(16'hFFFF);
    send_reading(16'h0008);
    write_reg(clm_pkg::REG_MAG_HI, 24'h800000);
    write_reg(clm_pkg::REG_MAG_LO, 24'h7FFFFF);
    send_reading(16'hFFFF);
    write_reg(clm_pkg::REG_UNUSED, 24'hFFFFFF);
    send_reading(16'h8000);
    set_calibration(8'd255, 8'd0, 16'hFFFF, 16'hFFFE, 24'd0, 24'd1, 24'h800000);
    send_reading(16'hFFFF);
    send_reading(16'h0000);
  endtask

  // random calibrations with random words, with and without idle gaps
  task automatic test_random();
    int pcts[4] = '{0, 57, 0, 27};
    for (int blk = 0; blk < 24; blk++) begin
      idle_pct = pcts[blk % 4];
      if (blk % 6 == 5)
        set_calibration(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                        24'($urandom), 24'($urandom), 24'($urandom));
      else
        set_calibration(8'($urandom_range(8)), 8'($urandom_range(30, 9)),
                        16'($urandom_range(8000)), 16'($urandom_range(30000, 10000)),
                        24'($urandom_range(2000) - 1000), 24'($urandom_range(100000)),
                        24'($urandom_range(200) - 100));
      for (int k = 0; k < 25; k++) begin
        if (blk == 10 && k == 12) drain();
        send_reading(16'($urandom_range(16'hFFFF)));
      end
    end
  endtask

  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    start = 1'b0;
    in_reading_word = '0;
    cfg_we = 1'b0;
    cfg_index = clm_pkg::REG_NOM_LO;
    cfg_wdata = '0;
    cycles = 0;
    errors = 0;
    beats_sent = 0;
    beats_seen = 0;
    cfg_writes = 0;
    idle_pct = 0;
    nom_lo = 8'd0;
    nom_hi = 8'd20;
    meas_lo = 16'd0;
    meas_hi = 16'd20480;
    mag_lo = 24'sd0;
    mag_hi = 24'sd6000;
    mag_off = 24'sd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_default_cal();
    test_nominal_zero();
    test_measured_zero();
    test_edges();
    test_random();
    drain();

    $display("covered %0d beats, %0d results, %0d register writes", beats_sent,
             beats_seen, cfg_writes);
    $display("span errors, reversed slopes, snap and saturation all exercised");
    if (errors == 0 && pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/clm_pkg.sv
rtl/clm_front.sv
rtl/clm_div_stage.sv
rtl/current_loop_to_magnitude.sv
rtl/clm_checker.sv
bench/tb_top.sv
